// ===== rtl/ipv4_header_builder_defines.svh =====
// Assertion macros used by the IPv4 header builder top level.
`ifndef IPV4_HEADER_BUILDER_DEFINES_SVH
`define IPV4_HEADER_BUILDER_DEFINES_SVH

// checked only out of reset
`define IHB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked on every edge, reset included
`define IHB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== rtl/ipv4hb_pkg.sv =====
// Types and constants for the IPv4 header builder.
`timescale 1ns / 1ps
package ipv4hb_pkg;

    localparam int ADDR_W = 4;

    localparam logic [7:0]  HDR_VER_IHL  = 8'h45;
    localparam logic [7:0]  HDR_TOS      = 8'h00;
    localparam logic [7:0]  HDR_TTL      = 8'd64;
    localparam logic [15:0] HDR_FLAGS_DF = 16'h4000;
    localparam logic [15:0] HDR_BYTES    = 16'd20;

    typedef enum logic [1:0] {
        REG_HOST_IP     = 2'd0,
        REG_SUBNET_MASK = 2'd1,
        REG_GATEWAY_IP  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] total_len;
        logic [15:0] ident;
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } hdr_fields_t;

endpackage

// ===== rtl/ipv4_header_builder.sv =====
// IPv4 header builder top level: register port, ident counter, two-stage pipe.
// Each request passes the input register, then the result register.
// Throughput: one request per cycle unless stalled; set by the single pass between registers.
// Backpressure stalls both stages; input is taken while a result waits only if stage 1 is empty.
// Reset (aresetn low, synchronous): clears valids, ident counter and config registers.
`timescale 1ns / 1ps
`include "ipv4_header_builder_defines.svh"
module ipv4_header_builder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipv4hb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [31:0]                   s_dest_ip,
    input  logic [15:0]                   s_payload_len,
    input  logic [7:0]                    s_protocol_num,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_header_word0,
    output logic [31:0]                   m_header_word1,
    output logic [31:0]                   m_header_word2,
    output logic [31:0]                   m_header_word3,
    output logic [31:0]                   m_header_word4,
    output logic [31:0]                   m_next_hop_ip,
    output logic                          m_via_gateway
);
    import ipv4hb_pkg::*;

    logic [31:0] host_ip_reg, subnet_mask_reg, gateway_ip_reg;
    logic [15:0] ident_reg;
    reg_idx_t    cfg_idx;
    logic        cfg_wr;

    logic        s1_valid_reg;
    logic [31:0] s1_dest_reg;
    logic [15:0] s1_plen_reg;
    logic [7:0]  s1_proto_reg;
    logic [15:0] s1_ident_reg;

    logic        m_valid_reg;
    logic [31:0] m_word0_reg, m_word1_reg, m_word2_reg, m_word3_reg, m_word4_reg;
    logic [31:0] m_hop_reg;
    logic        m_via_reg;

    logic        s_accept, out_load;
    hdr_fields_t hdr;
    logic [15:0] csum;
    logic        redirect;
    logic [31:0] word0_next, word1_next, word2_next, hop_next;

    // register port
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_HOST_IP:     prdata = host_ip_reg;
            REG_SUBNET_MASK: prdata = subnet_mask_reg;
            REG_GATEWAY_IP:  prdata = gateway_ip_reg;
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_ip_reg     <= 32'd0;
            subnet_mask_reg <= 32'd0;
            gateway_ip_reg  <= 32'd0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_HOST_IP:     host_ip_reg     <= pwdata;
                REG_SUBNET_MASK: subnet_mask_reg <= pwdata;
                REG_GATEWAY_IP:  gateway_ip_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    assign out_load = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_load;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ident_reg    <= 16'd0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                ident_reg <= ident_reg + 16'd1;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (out_load) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_dest_reg  <= s_dest_ip;
            s1_plen_reg  <= s_payload_len;
            s1_proto_reg <= s_protocol_num;
            s1_ident_reg <= ident_reg;
        end
    end

    // header build
    always_comb begin
        hdr.total_len = s1_plen_reg + HDR_BYTES;
        hdr.ident     = s1_ident_reg;
        hdr.protocol  = s1_proto_reg;
        hdr.src_ip    = host_ip_reg;
        hdr.dst_ip    = s1_dest_reg;
    end

    ipv4hb_csum u_csum (
        .hdr  (hdr),
        .csum (csum)
    );

    always_comb begin
        redirect = (subnet_mask_reg != 32'd0) && (host_ip_reg != 32'd0) &&
                   (s1_dest_reg != 32'd0) &&
                   ((host_ip_reg & subnet_mask_reg) != (s1_dest_reg & subnet_mask_reg));
        word0_next = {HDR_VER_IHL, HDR_TOS, hdr.total_len};
        word1_next = {hdr.ident, HDR_FLAGS_DF};
        word2_next = {HDR_TTL, hdr.protocol, csum};
        hop_next   = redirect ? gateway_ip_reg : s1_dest_reg;
    end

    always_ff @(posedge aclk) begin
        if (out_load && s1_valid_reg) begin
            m_word0_reg <= word0_next;
            m_word1_reg <= word1_next;
            m_word2_reg <= word2_next;
            m_word3_reg <= host_ip_reg;
            m_word4_reg <= s1_dest_reg;
            m_hop_reg   <= hop_next;
            m_via_reg   <= redirect;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_header_word0 = m_word0_reg;
    assign m_header_word1 = m_word1_reg;
    assign m_header_word2 = m_word2_reg;
    assign m_header_word3 = m_word3_reg;
    assign m_header_word4 = m_word4_reg;
    assign m_next_hop_ip  = m_hop_reg;
    assign m_via_gateway  = m_via_reg;

    `IHB_ASSERT(a_ident_step, s_accept |=> ident_reg == $past(ident_reg) + 16'd1, "ident step")
    `IHB_ASSERT(a_ident_hold, !s_accept |=> $stable(ident_reg), "ident moved without request")
    `IHB_ASSERT(a_via_addr, (m_valid && m_via_gateway) |-> (m_header_word3 != 32'd0 && m_header_word4 != 32'd0), "redirect with zero address")
    `IHB_ASSERT(a_direct_hop, (m_valid && !m_via_gateway) |-> m_next_hop_ip == m_header_word4, "direct hop mismatch")
    `IHB_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> (!m_valid_reg && !s1_valid_reg && ident_reg == 16'd0), "reset did not clear")

endmodule

// ===== rtl/ipv4hb_csum.sv =====
// IPv4 header checksum: ones'-complement sum of the nine halfwords other than the checksum field, folded.
`timescale 1ns / 1ps
module ipv4hb_csum (
    input  ipv4hb_pkg::hdr_fields_t hdr,
    output logic [15:0]             csum
);
    import ipv4hb_pkg::*;

    logic [19:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_comb begin
        sum = {4'd0, HDR_VER_IHL, HDR_TOS}
            + {4'd0, hdr.total_len}
            + {4'd0, hdr.ident}
            + {4'd0, HDR_FLAGS_DF}
            + {4'd0, HDR_TTL, hdr.protocol}
            + {4'd0, hdr.src_ip[31:16]}
            + {4'd0, hdr.src_ip[15:0]}
            + {4'd0, hdr.dst_ip[31:16]}
            + {4'd0, hdr.dst_ip[15:0]};
        // two end-around folds always clear the carry for a 20-bit sum
        fold1 = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};
        csum  = ~fold2;
    end

endmodule

// ===== dv/ipv4_header_builder_checker.sv =====
`timescale 1ns / 1ps
// Checker for the IPv4 header builder: mirrors register writes, predicts headers, compares.
module ipv4_header_builder_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipv4hb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    input  logic [31:0]                   prdata,
    input  logic                          pready,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [31:0]                   s_dest_ip,
    input  logic [15:0]                   s_payload_len,
    input  logic [7:0]                    s_protocol_num,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [31:0]                   m_header_word0,
    input  logic [31:0]                   m_header_word1,
    input  logic [31:0]                   m_header_word2,
    input  logic [31:0]                   m_header_word3,
    input  logic [31:0]                   m_header_word4,
    input  logic [31:0]                   m_next_hop_ip,
    input  logic                          m_via_gateway,
    output int                            mismatches,
    output int                            hdrs_in_flight
);
    import ipv4hb_pkg::*;

    typedef struct {
        logic [31:0] word0;
        logic [31:0] word1;
        logic [31:0] word2;
        logic [31:0] word3;
        logic [31:0] word4;
        logic [31:0] next_hop;
        logic        via_gw;
    } ipv4_hdr_t;

    logic [31:0] host_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
    logic [15:0] ident;
    ipv4_hdr_t   pending_hdrs[$];
    int          err_cnt;

    initial begin
        mismatches     = 0;
        hdrs_in_flight = 0;
        err_cnt        = 0;
    end

    function automatic ipv4_hdr_t build_header(input logic [31:0] dest,
                                               input logic [15:0] plen,
                                               input logic [7:0]  proto);
        ipv4_hdr_t   h;
        logic [31:0] w [5];
        logic [31:0] acc;
        logic [15:0] total;
        logic        redirect;
        total = plen + HDR_BYTES;
        w[0]  = {HDR_VER_IHL, HDR_TOS, total};
        w[1]  = {ident, HDR_FLAGS_DF};
        w[2]  = {HDR_TTL, proto, 16'h0000};
        w[3]  = host_ip;
        w[4]  = dest;
        acc   = 32'h0;
        for (int i = 0; i < 5; i++) begin
            acc += {16'h0, w[i][31:16]} + {16'h0, w[i][15:0]};
        end
        while (acc[31:16] != 16'h0) begin
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        end
        w[2][15:0] = ~acc[15:0];
        redirect = (subnet_mask != 0) && (host_ip != 0) && (dest != 0) &&
                   ((host_ip & subnet_mask) != (dest & subnet_mask));
        h.word0    = w[0];
        h.word1    = w[1];
        h.word2    = w[2];
        h.word3    = w[3];
        h.word4    = w[4];
        h.next_hop = redirect ? gateway_ip : dest;
        h.via_gw   = redirect;
        return h;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        ipv4_hdr_t want;
        if (!aresetn) begin
            host_ip     = 32'h0;
            subnet_mask = 32'h0;
            gateway_ip  = 32'h0;
            ident       = 16'h0;
            pending_hdrs.delete();
        end else begin
            if (s_valid && s_ready) begin
                pending_hdrs.push_back(build_header(s_dest_ip, s_payload_len, s_protocol_num));
                ident = ident + 16'd1;
            end
            if (m_valid && m_ready) begin
                if (pending_hdrs.size() == 0) begin
                    $error("header result with no request pending");
                    err_cnt++;
                end else begin
                    want = pending_hdrs.pop_front();
                    check_field("header_word0", want.word0, m_header_word0);
                    check_field("header_word1", want.word1, m_header_word1);
                    check_field("header_word2", want.word2, m_header_word2);
                    check_field("header_word3", want.word3, m_header_word3);
                    check_field("header_word4", want.word4, m_header_word4);
                    check_field("next_hop_ip", want.next_hop, m_next_hop_ip);
                    check_field("via_gateway", {31'h0, want.via_gw}, {31'h0, m_via_gateway});
                end
            end
            if (psel && penable && pready && !pwrite) begin
                case (paddr)
                    {REG_HOST_IP, 2'b00}:     check_field("prdata host_ip", host_ip, prdata);
                    {REG_SUBNET_MASK, 2'b00}: check_field("prdata subnet_mask", subnet_mask, prdata);
                    {REG_GATEWAY_IP, 2'b00}:  check_field("prdata gateway_ip", gateway_ip, prdata);
                    default: ;
                endcase
            end
            if (psel && penable && pready && pwrite) begin
                case (paddr)
                    {REG_HOST_IP, 2'b00}:     host_ip     = pwdata;
                    {REG_SUBNET_MASK, 2'b00}: subnet_mask = pwdata;
                    {REG_GATEWAY_IP, 2'b00}:  gateway_ip  = pwdata;
                    default: ;
                endcase
            end
        end
        hdrs_in_flight <= pending_hdrs.size();
        mismatches     <= err_cnt;
    end

endmodule

// ===== dv/ipv4_header_builder_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the IPv4 header builder: clock, reset, register setup, requests, verdict.
module ipv4_header_builder_tb;
    import ipv4hb_pkg::*;

    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 4'hC;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [ADDR_W-1:0] paddr          = '0;
    logic [31:0]       pwdata         = 32'h0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [31:0]       s_dest_ip      = 32'h0;
    logic [15:0]       s_payload_len  = 16'h0;
    logic [7:0]        s_protocol_num = 8'h0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [31:0]       m_header_word0;
    logic [31:0]       m_header_word1;
    logic [31:0]       m_header_word2;
    logic [31:0]       m_header_word3;
    logic [31:0]       m_header_word4;
    logic [31:0]       m_next_hop_ip;
    logic              m_via_gateway;
    int                mismatches;
    int                hdrs_in_flight;

    bit                idle_on        = 1'b1;
    logic [31:0]       cur_host       = 32'h0;
    logic [31:0]       cur_mask       = 32'h0;

    ipv4_header_builder u_dut (.*);

    ipv4_header_builder_checker u_checker (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 35);
    end

    initial begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

    task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [31:0] host, input logic [31:0] mask,
                              input logic [31:0] gw);
        apb_xfer(1'b1, {REG_HOST_IP, 2'b00}, host);
        apb_xfer(1'b1, {REG_SUBNET_MASK, 2'b00}, mask);
        apb_xfer(1'b1, {REG_GATEWAY_IP, 2'b00}, gw);
        apb_xfer(1'b0, {REG_HOST_IP, 2'b00}, 32'h0);
        apb_xfer(1'b0, {REG_SUBNET_MASK, 2'b00}, 32'h0);
        apb_xfer(1'b0, {REG_GATEWAY_IP, 2'b00}, 32'h0);
        cur_host = host;
        cur_mask = mask;
    endtask

    task automatic send_req(input logic [31:0] dest, input logic [15:0] plen,
                            input logic [7:0] proto);
        while (idle_on && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_dest_ip      <= dest;
        s_payload_len  <= plen;
        s_protocol_num <= proto;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // lower valid and hold until every header has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (hdrs_in_flight != 0) @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        logic [31:0] dest;
        logic [15:0] plen;
        logic [7:0]  proto;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: dest = (cur_host & cur_mask) | ($urandom & ~cur_mask);
                5:             dest = 32'h0;
                6:             dest = cur_host;
                default:       dest = $urandom;
            endcase
            case ($urandom_range(9))
                0:       plen = 16'd0;
                1:       plen = 16'd65515;
                2:       plen = 16'($urandom_range(65535, 65516));
                3, 4, 5: plen = 16'($urandom_range(1480));
                default: plen = 16'($urandom);
            endcase
            proto = 8'($urandom_range(255));
            send_req(dest, plen, proto);
        end
    endtask

    initial begin
        logic [31:0] host;
        logic [31:0] mask;
        logic [31:0] gw;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config: no redirection possible
        send_req(32'hFFFFFFFF, 16'd0, 8'd0);
        send_req(32'h0A000001, 16'd65535, 8'd255);
        drain();

        apb_xfer(1'b1, UNMAPPED_ADDR, 32'hDEADBEEF);
        set_config(32'hC0A80105, 32'hFFFFFF00, 32'hC0A80101);
        send_req(32'hC0A80177, 16'd64, 8'd6);
        send_req(32'h08080808, 16'd1480, 8'd17);
        send_req(32'h00000000, 16'd0, 8'd1);
        send_req(32'h08080808, 16'd65515, 8'd0);
        send_req(32'h08080808, 16'd65516, 8'd255);
        send_req(32'hC0A801FF, 16'd65535, 8'd255);
        send_req(32'hFFFFFFFF, 16'd20, 8'd6);
        send_req(32'hC0A80105, 16'd1, 8'd17);
        drain();

        // redirect to a zero gateway
        set_config(32'hC0A80105, 32'hFFFFFF00, 32'h0);
        send_req(32'h08080808, 16'd100, 8'd6);
        drain();

        set_config(32'h0, 32'hFFFFFF00, 32'hC0A80101);
        send_req(32'h08080808, 16'd100, 8'd6);
        drain();

        set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_req(32'hFFFFFFFE, 16'd65535, 8'd255);
        send_req(32'hFFFFFFFF, 16'd0, 8'd0);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case ($urandom_range(3))
                0:       host = 32'h0;
                1:       host = 32'hFFFFFFFF;
                default: host = $urandom;
            endcase
            if ($urandom_range(4) == 0) begin
                mask = $urandom;
            end else begin
                mask = 32'hFFFFFFFF << (32 - $urandom_range(32));
            end
            gw = ($urandom_range(5) == 0) ? 32'h0 : $urandom;
            idle_on <= (ph != 3);
            set_config(host, mask, gw);
            send_random(125);
            drain();
        end

        // back to back with no idling on either side
        idle_on <= 1'b0;
        set_config($urandom, 32'hFFFF0000, $urandom);
        send_random(125);
        drain();

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
